### rtl/phne_pkg.sv
// Package: shared types and constants for the packet host name extractor.
`default_nettype none
package phne_pkg;
  localparam int unsigned OffsetBitsDef  = 16;
  localparam int unsigned RecHdrBytesDef = 5;
  localparam logic [15:0] HttpPortRst = 16'd80;
  localparam logic [15:0] TlsPortRst  = 16'd443;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgHttpPort = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgTlsPort  = 1'd1;

  localparam logic [1:0] StHttp   = 2'd0;
  localparam logic [1:0] StSni    = 2'd1;
  localparam logic [1:0] StNoHost = 2'd2;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] dest_port;
    logic [15:0] src_port;
  } in_item_t;

  typedef struct packed {
    logic [7:0] host_byte;
    logic       is_status;
    logic [1:0] status;
    logic       run_end;
  } out_item_t;

  // Result of parsing one byte, passed from the parser to the output stage.
  typedef struct packed {
    logic       emit;
    logic       last;
    logic [7:0] data;
    logic [1:0] status;
  } parse_res_t;
endpackage
`default_nettype wire

### rtl/phne_stream_if.sv
// Interface: valid/ready stream channel carrying a payload.
`default_nettype none
interface phne_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/phne_parser.sv
// Parser: per-byte HTTP Host and TLS SNI state machine.
`default_nettype none
module phne_parser #(
  parameter int unsigned OffsetBits  = phne_pkg::OffsetBitsDef,
  parameter int unsigned RecHdrBytes = phne_pkg::RecHdrBytesDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire phne_pkg::in_item_t   item_i,
  input  wire logic [15:0]          http_port_i,
  input  wire logic [15:0]          tls_port_i,
  output phne_pkg::parse_res_t      res_o
);
  import phne_pkg::*;

  typedef enum logic [1:0] {MIdle, MHttp, MTls, MNone} mode_e;
  typedef enum logic [4:0] {
    PSearch, PHskip, PHname, PHlen, PVrand, PSidlen, PSid, PCslenHi, PCslenLo,
    PCs, PCmlen, PCm, PExlenHi, PExlenLo, PExtT0, PExtT1, PExtL0, PExtL1,
    PExtSkip, PSniList0, PSniList1, PSniType, PSniNlen0, PSniNlen1, PSniName,
    POk, PFail
  } phase_e;

  localparam logic [OffsetBits-1:0] OffMax = '1;
  localparam logic [OffsetBits-1:0] RecHdr = OffsetBits'(RecHdrBytes);

  mode_e mode_q, mode_d, md;
  phase_e ph_q, ph_d, ph;
  logic [OffsetBits-1:0] off_q, off_d, off;
  logic [2:0]  hmi_q, hmi_d, hmi;
  logic [16:0] skip_q, skip_d, skip;
  logic [7:0]  lat_q, lat_d, lat;
  logic [17:0] exe_q, exe_d, exe;
  logic        ext0_q, ext0_d, ext0;
  logic        hne_q, hne_d, hne;
  logic [16:0] skm1;
  logic [17:0] exm1;
  logic [15:0] len16;
  logic [7:0]  b, tag;
  logic        emit, term;

  always_comb begin
    b = item_i.data_byte;
    md = mode_q; ph = ph_q; off = off_q; hmi = hmi_q; skip = skip_q;
    lat = lat_q; exe = exe_q; ext0 = ext0_q; hne = hne_q;
    if (item_i.first_byte) begin
      ph = PSearch; off = '0; hmi = '0; skip = '0; lat = '0; exe = '0;
      ext0 = 1'b1; hne = 1'b0;
      if (item_i.dest_port == http_port_i || item_i.src_port == http_port_i) begin
        md = MHttp;
      end else if (item_i.dest_port == tls_port_i || item_i.src_port == tls_port_i) begin
        md = MTls;
      end else begin
        md = MNone;
      end
    end
    mode_d = md; ph_d = ph; off_d = off; hmi_d = hmi; skip_d = skip; lat_d = lat;
    exe_d = exe; ext0_d = ext0; hne_d = hne;
    emit = 1'b0;
    skm1 = skip - 17'd1;
    exm1 = exe - 18'd1;
    len16 = {lat, b};
    term = (b == 8'h0d) || (b == 8'h0a) || (b == 8'h20) || (b == 8'h09);
    unique case (hmi)
      3'd0: tag = 8'h48;
      3'd1: tag = 8'h6f;
      3'd2: tag = 8'h73;
      3'd3: tag = 8'h74;
      default: tag = 8'h3a;
    endcase
    if (md == MHttp) begin
      unique case (ph)
        PSearch: begin
          if (b == tag) begin
            if (hmi == 3'd4) begin
              hmi_d = '0; ph_d = PHskip;
            end else begin
              hmi_d = hmi + 3'd1;
            end
          end else begin
            hmi_d = (b == 8'h48) ? 3'd1 : 3'd0;
          end
        end
        PHskip: begin
          if (b == 8'h20 || b == 8'h09) begin
            ph_d = PHskip;
          end else if (term || b == 8'h3a) begin
            ph_d = PFail;
          end else begin
            hne_d = 1'b1; ph_d = PHname; emit = 1'b1;
          end
        end
        PHname: begin
          if (term || b == 8'h3a) ph_d = POk;
          else emit = 1'b1;
        end
        default: ;
      endcase
    end else if (md == MTls) begin
      unique case (ph)
        PSearch: begin
          if (off == '0) begin
            if (b != 8'h16) ph_d = PFail;
          end else if (off >= RecHdr && b == 8'h01) begin
            skip_d = 17'd3; ph_d = PHlen;
          end
        end
        PHlen: begin
          skip_d = skm1;
          if (skm1 == '0) begin
            skip_d = 17'd34; ph_d = PVrand;
          end
        end
        PVrand: begin
          skip_d = skm1;
          if (skm1 == '0) ph_d = PSidlen;
        end
        PSidlen: begin
          if (b == '0) ph_d = PCslenHi;
          else begin
            skip_d = 17'(b); ph_d = PSid;
          end
        end
        PSid: begin
          skip_d = skm1;
          if (skm1 == '0) ph_d = PCslenHi;
        end
        PCslenHi: begin
          lat_d = b; ph_d = PCslenLo;
        end
        PCslenLo: begin
          if (len16 == '0) ph_d = PCmlen;
          else begin
            skip_d = 17'(len16); ph_d = PCs;
          end
        end
        PCs: begin
          skip_d = skm1;
          if (skm1 == '0) ph_d = PCmlen;
        end
        PCmlen: begin
          if (b == '0) ph_d = PExlenHi;
          else begin
            skip_d = 17'(b); ph_d = PCm;
          end
        end
        PCm: begin
          skip_d = skm1;
          if (skm1 == '0) ph_d = PExlenHi;
        end
        PExlenHi: begin
          lat_d = b; ph_d = PExlenLo;
        end
        PExlenLo: begin
          exe_d = 18'(len16);
          ph_d = (len16 >= 16'd4) ? PExtT0 : PFail;
        end
        PExtT0: begin
          lat_d = b; exe_d = exm1; ph_d = PExtT1;
        end
        PExtT1: begin
          ext0_d = (lat == '0) && (b == '0); exe_d = exm1; ph_d = PExtL0;
        end
        PExtL0: begin
          lat_d = b; exe_d = exm1; ph_d = PExtL1;
        end
        PExtL1: begin
          exe_d = exm1;
          if (ext0) begin
            ph_d = (exm1 >= 18'd2) ? PSniList0 : PFail;
          end else if (18'(len16) + 18'd4 > exm1) begin
            ph_d = PFail;
          end else if (len16 == '0) begin
            ph_d = (exm1 >= 18'd4) ? PExtT0 : PFail;
          end else begin
            skip_d = 17'(len16); ph_d = PExtSkip;
          end
        end
        PExtSkip: begin
          exe_d = exm1; skip_d = skm1;
          if (skm1 == '0) ph_d = (exm1 >= 18'd4) ? PExtT0 : PFail;
        end
        PSniList0: begin
          exe_d = exm1; ph_d = PSniList1;
        end
        PSniList1: begin
          exe_d = exm1; ph_d = (exm1 >= 18'd1) ? PSniType : PFail;
        end
        PSniType: begin
          exe_d = exm1;
          if (b != '0) ph_d = PFail;
          else ph_d = (exm1 >= 18'd2) ? PSniNlen0 : PFail;
        end
        PSniNlen0: begin
          lat_d = b; exe_d = exm1; ph_d = PSniNlen1;
        end
        PSniNlen1: begin
          exe_d = exm1;
          if (18'(len16) > exm1) ph_d = PFail;
          else if (len16 == '0) ph_d = POk;
          else begin
            skip_d = 17'(len16); ph_d = PSniName;
          end
        end
        PSniName: begin
          emit = 1'b1; skip_d = skm1;
          if (skm1 == '0) ph_d = POk;
        end
        default: ;
      endcase
    end
    if (off < OffMax) off_d = off + 1'b1;
    res_o.emit = 1'b0;
    res_o.last = 1'b0;
    res_o.data = b;
    if (md == MHttp) res_o.status = hne_d ? StHttp : StNoHost;
    else if (md == MTls) res_o.status = (ph_d == POk) ? StSni : StNoHost;
    else res_o.status = StNoHost;
    if (md != MIdle) begin
      res_o.emit = emit;
      res_o.last = item_i.last_byte;
    end
    if (item_i.last_byte || md == MIdle) begin
      mode_d = MIdle; ph_d = PSearch; off_d = '0; hmi_d = '0; skip_d = '0;
      lat_d = '0; exe_d = '0; ext0_d = 1'b1; hne_d = 1'b0;
    end
    if (!step_i) begin
      res_o.emit = 1'b0;
      res_o.last = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MIdle; ph_q <= PSearch; off_q <= '0; hmi_q <= '0; skip_q <= '0;
      lat_q <= '0; exe_q <= '0; ext0_q <= 1'b1; hne_q <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d; ph_q <= ph_d; off_q <= off_d; hmi_q <= hmi_d;
      skip_q <= skip_d; lat_q <= lat_d; exe_q <= exe_d; ext0_q <= ext0_d;
      hne_q <= hne_d;
    end
  end
endmodule
`default_nettype wire

### rtl/phne_out_stage.sv
// Output stage: holds up to two pending results and serializes them.
`default_nettype none
module phne_out_stage (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire phne_pkg::parse_res_t res_i,
  output logic                      can_take_o,
  phne_stream_if.source             out_o
);
  import phne_pkg::*;

  logic       hb_q, st_q, hb_d, st_d;
  logic [7:0] byte_q;
  logic [1:0] stat_q;
  logic       pop;

  assign pop = out_o.valid && out_o.ready;
  assign can_take_o = !(hb_q || st_q) || (pop && !(hb_q && st_q));
  assign out_o.valid = hb_q || st_q;
  always_comb begin
    out_o.data.host_byte = hb_q ? byte_q : 8'd0;
    out_o.data.is_status = !hb_q;
    out_o.data.status    = hb_q ? StHttp : stat_q;
    out_o.data.run_end   = !(hb_q && st_q);
    hb_d = hb_q; st_d = st_q;
    if (pop) begin
      if (hb_q) hb_d = 1'b0;
      else st_d = 1'b0;
    end
    if (res_i.emit) hb_d = 1'b1;
    if (res_i.last) st_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_q <= 1'b0; st_q <= 1'b0;
    end else begin
      hb_q <= hb_d; st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.emit) byte_q <= res_i.data;
    if (res_i.last) stat_q <= res_i.status;
  end
endmodule
`default_nettype wire

### rtl/packet_host_name_extractor_unit.sv
// Top level: packet host name extractor (HTTP Host header and TLS SNI).
`default_nettype none
// One payload byte is taken per clock cycle while the output stage has room;
// each transaction yields at most two results (a host byte and, on the last
// byte, a status), which drain one per cycle. The parse state machine updates
// in the same cycle a byte is accepted, so bytes run at full rate while the
// consumer keeps up; two results stall input until one drains. The user must
// write port registers through cfg_we_i only while idle; it is not enforced.
module packet_host_name_extractor_unit #(
  parameter int unsigned OffsetBits  = phne_pkg::OffsetBitsDef,
  parameter int unsigned RecHdrBytes = phne_pkg::RecHdrBytesDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [phne_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [15:0]                   cfg_wdata_i,
  phne_stream_if.sink                        in_i,
  phne_stream_if.source                      out_o
);
  import phne_pkg::*;

  logic [15:0] http_port_q, tls_port_q;
  logic        can_take, step;
  parse_res_t  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      http_port_q <= HttpPortRst;
      tls_port_q  <= TlsPortRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHttpPort: http_port_q <= cfg_wdata_i;
        CfgTlsPort:  tls_port_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_i.ready = can_take;
  assign step = in_i.valid && can_take;

  phne_parser #(.OffsetBits(OffsetBits), .RecHdrBytes(RecHdrBytes)) u_parser (
    .clk_i, .rst_ni, .step_i(step), .item_i(in_i.data),
    .http_port_i(http_port_q), .tls_port_i(tls_port_q), .res_o(res)
  );

  phne_out_stage u_out (
    .clk_i, .rst_ni, .res_i(res), .can_take_o(can_take), .out_o(out_o)
  );

`ifndef SYNTHESIS
  a_no_take_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready && !out_o.data.run_end) |-> !in_i.ready)
    else $error("input taken with two results pending");
  a_status_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.is_status) |-> out_o.data.run_end)
    else $error("status result not marked run end");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.data.status != 2'd3))
    else $error("bad status code");
`endif
endmodule
`default_nettype wire
